>>> hdl/multi_channel_byte_fifo_pool_assert.svh
// Assertion macros shared by the byte FIFO pool RTL.
`ifndef MULTI_CHANNEL_BYTE_FIFO_POOL_ASSERT_SVH
`define MULTI_CHANNEL_BYTE_FIFO_POOL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MCBFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MCBFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mcbfp_pkg.sv
// Constants, codes and a helper function for the byte FIFO pool.
package mcbfp_pkg;

	localparam int CHANNELS   = 16;
	localparam int RING_DEPTH = 512;
	localparam int RESERVED   = 3;

	localparam int CH_W   = 4;
	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int ADDR_W = $clog2(CHANNELS * RING_DEPTH);
	localparam int CNT_W  = $clog2(CHANNELS + 1);
	localparam int CMD_W  = 3;
	localparam int STS_W  = 3;
	localparam int BYTE_W = 8;
	localparam int TDATA_W = 16;

	localparam int REG_OUT_CHANNEL = 0;
	localparam int REG_ERR_CHANNEL = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_CLOSE  = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_READ   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK      = 3'd0,
		STS_BAD_CH  = 3'd1,
		STS_NO_FREE = 3'd2,
		STS_FULL    = 3'd3,
		STS_EMPTY   = 3'd4
	} status_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CH_W-1:0]  ch_t;

	// Advance a ring pointer with wrap at the ring depth.
	function automatic ptr_t ring_next(input ptr_t p);
		ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

>>> hdl/multi_channel_byte_fifo_pool.sv
// Pool of byte ring buffers, one per channel, with channel allocation and a
// byte store held in one synchronous memory. An item's result is registered
// first in stage one and then in the output register, where a stall can hold
// it; with the output taken every cycle the block accepts one item per cycle.
// The ring store is a single-port memory with a registered read, used once
// per item for either the byte push or the byte pop; pointers, open flags and
// the count of allocated channels sit in flip-flops and are updated at the
// accepting edge, so the next item sees them at once. Channels below the
// reserved count are open from reset and cannot be closed. Reset needs no
// clearing pass: a byte is only ever read after it was written.
module multi_channel_byte_fifo_pool (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // cmd[2:0], channel[6:3], data_in[14:7], zero[15]
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status[2:0], new_channel[6:3], data_out[14:7], zero[15]
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	mcbfp_pkg::ch_t out_ch_q;
	mcbfp_pkg::ch_t err_ch_q;
	logic           reg_sel;

	// channel state
	logic [mcbfp_pkg::CHANNELS-1:0] open_q;
	mcbfp_pkg::ptr_t                rptr_q [mcbfp_pkg::CHANNELS];
	mcbfp_pkg::ptr_t                wptr_q [mcbfp_pkg::CHANNELS];
	logic [mcbfp_pkg::CNT_W-1:0]    created_q;

	// ring store
	logic [mcbfp_pkg::BYTE_W-1:0] ring_mem [mcbfp_pkg::CHANNELS * mcbfp_pkg::RING_DEPTH];
	logic [mcbfp_pkg::ADDR_W-1:0] mem_addr;
	logic                         mem_we;
	logic                         mem_re;
	logic [mcbfp_pkg::BYTE_W-1:0] rd_data_s1;

	// decode
	logic                          accept;
	logic [mcbfp_pkg::CMD_W-1:0]   cmd;
	mcbfp_pkg::ch_t                ch;
	logic [mcbfp_pkg::BYTE_W-1:0]  din;
	logic                          in_range;
	logic                          ch_open;
	logic                          forbidden;
	mcbfp_pkg::ptr_t               rptr;
	mcbfp_pkg::ptr_t               wptr;
	mcbfp_pkg::ptr_t               wptr_nx;
	logic                          free_found;
	mcbfp_pkg::ch_t                free_idx;
	mcbfp_pkg::status_t            status;
	mcbfp_pkg::ch_t                new_ch;
	logic                          ok;

	// pipeline and output
	logic               s1_valid_q;
	mcbfp_pkg::status_t status_s1;
	mcbfp_pkg::ch_t     new_ch_s1;
	logic               rd_s1;
	logic               advance;
	logic               m_valid_q;
	logic [15:0]        m_data_q;
	logic [mcbfp_pkg::BYTE_W-1:0] dout;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch_q <= mcbfp_pkg::CH_W'(1);
			err_ch_q <= mcbfp_pkg::CH_W'(2);
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == 1'(mcbfp_pkg::REG_OUT_CHANNEL)) begin
				out_ch_q <= pwdata[mcbfp_pkg::CH_W-1:0];
			end else begin
				err_ch_q <= pwdata[mcbfp_pkg::CH_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == 1'(mcbfp_pkg::REG_OUT_CHANNEL)) begin
			prdata = {{(32-mcbfp_pkg::CH_W){1'b0}}, out_ch_q};
		end else begin
			prdata = {{(32-mcbfp_pkg::CH_W){1'b0}}, err_ch_q};
		end
	end

	// ---------------- item decode ----------------
	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	assign cmd = s_tdata[2:0];
	assign ch  = s_tdata[6:3];
	assign din = s_tdata[14:7];

	assign in_range  = (32'(ch) < mcbfp_pkg::CHANNELS);
	assign ch_open   = in_range && open_q[ch];
	assign forbidden = (ch == out_ch_q) || (ch == err_ch_q);
	assign rptr      = rptr_q[ch];
	assign wptr      = wptr_q[ch];
	assign wptr_nx   = mcbfp_pkg::ring_next(wptr);

	// lowest free channel above the reserved ones
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = mcbfp_pkg::CHANNELS - 1; i >= mcbfp_pkg::RESERVED; i--) begin
			if (!open_q[i]) begin
				free_found = 1'b1;
				free_idx   = mcbfp_pkg::CH_W'(i);
			end
		end
	end

	always_comb begin
		status = mcbfp_pkg::STS_BAD_CH;
		new_ch = '0;
		case (cmd)
			mcbfp_pkg::CMD_CREATE: begin
				status = mcbfp_pkg::STS_NO_FREE;
				if (32'(created_q) < mcbfp_pkg::CHANNELS - mcbfp_pkg::RESERVED && free_found) begin
					status = mcbfp_pkg::STS_OK;
					new_ch = free_idx;
				end
			end
			mcbfp_pkg::CMD_CLOSE: begin
				if (32'(ch) >= mcbfp_pkg::RESERVED && ch_open) begin
					status = mcbfp_pkg::STS_OK;
				end
			end
			mcbfp_pkg::CMD_WRITE: begin
				if (!forbidden && ch_open) begin
					status = (wptr_nx == rptr) ? mcbfp_pkg::STS_FULL : mcbfp_pkg::STS_OK;
				end
			end
			mcbfp_pkg::CMD_READ: begin
				if (!forbidden && ch_open) begin
					status = (rptr == wptr) ? mcbfp_pkg::STS_EMPTY : mcbfp_pkg::STS_OK;
				end
			end
			mcbfp_pkg::CMD_CLEAR: begin
				if (ch_open) begin
					status = mcbfp_pkg::STS_OK;
				end
			end
			default: begin
				status = mcbfp_pkg::STS_BAD_CH;
			end
		endcase
	end

	assign ok = (status == mcbfp_pkg::STS_OK);

	// ---------------- channel state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcbfp_pkg::CHANNELS; i++) begin
				open_q[i] <= (i < mcbfp_pkg::RESERVED);
				rptr_q[i] <= '0;
				wptr_q[i] <= '0;
			end
			created_q <= '0;
		end else if (accept && ok) begin
			case (cmd)
				mcbfp_pkg::CMD_CREATE: begin
					open_q[free_idx] <= 1'b1;
					rptr_q[free_idx] <= '0;
					wptr_q[free_idx] <= '0;
					created_q        <= created_q + mcbfp_pkg::CNT_W'(1);
				end
				mcbfp_pkg::CMD_CLOSE: begin
					open_q[ch] <= 1'b0;
					rptr_q[ch] <= '0;
					wptr_q[ch] <= '0;
					created_q  <= created_q - mcbfp_pkg::CNT_W'(1);
				end
				mcbfp_pkg::CMD_WRITE: begin
					wptr_q[ch] <= wptr_nx;
				end
				mcbfp_pkg::CMD_READ: begin
					rptr_q[ch] <= mcbfp_pkg::ring_next(rptr);
				end
				mcbfp_pkg::CMD_CLEAR: begin
					rptr_q[ch] <= '0;
					wptr_q[ch] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- ring store ----------------
	assign mem_we   = accept && ok && (cmd == mcbfp_pkg::CMD_WRITE);
	assign mem_re   = accept && ok && (cmd == mcbfp_pkg::CMD_READ);
	assign mem_addr = mcbfp_pkg::ADDR_W'(ch) * mcbfp_pkg::ADDR_W'(mcbfp_pkg::RING_DEPTH)
		+ mcbfp_pkg::ADDR_W'((cmd == mcbfp_pkg::CMD_WRITE) ? wptr : rptr);

	// read data holds while stage one is stalled, since no item is accepted then
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_addr] <= din;
		end
		if (mem_re) begin
			rd_data_s1 <= ring_mem[mem_addr];
		end
	end

	// ---------------- result pipeline ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			new_ch_s1 <= new_ch;
			rd_s1     <= ok && (cmd == mcbfp_pkg::CMD_READ);
		end
	end

	assign dout = rd_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_valid_q && advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && advance) begin
			m_data_q <= {1'b0, dout, new_ch_s1, status_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ---------------- assertions ----------------
	`include "multi_channel_byte_fifo_pool_assert.svh"

	`MCBFP_ASSERT_NOW(a_count_matches_flags, 1'b1, $countones(open_q) == 32'(created_q) + mcbfp_pkg::RESERVED, "allocated count disagrees with open flags")
	`MCBFP_ASSERT_NOW(a_reserved_open, 1'b1, &open_q[mcbfp_pkg::RESERVED-1:0], "reserved channel closed")
	`MCBFP_ASSERT_NOW(a_stall_blocks_input, s1_valid_q && m_valid_q && !m_tready, !s_tready, "item accepted while result pipeline is stalled")
	`MCBFP_ASSERT_NEXT(a_read_data_only_on_ok, s1_valid_q && advance && status_s1 != mcbfp_pkg::STS_OK, m_tdata[14:7] == '0, "data_out non-zero on a failed transaction")

endmodule
